// File: rtl/core/curtain_motor_frame_receiver_unit_macros.svh
// Assertion macros for the curtain motor frame receiver
`ifndef CURTAIN_MOTOR_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CURTAIN_MOTOR_FRAME_RECEIVER_UNIT_MACROS_SVH

// property checked at every clock edge out of reset
`define CMFR_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define CMFR_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

// File: rtl/core/cmfr_pkg.sv
// Package: types and constants for the curtain motor frame receiver
package cmfr_pkg;

  localparam int BUF_BYTES_DEFAULT = 128;
  localparam int LEN_W = 17;

  typedef enum logic [1:0] {
    REQ_RX   = 2'd0,
    REQ_STOP = 2'd1,
    REQ_MOVE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    FS_TAKEN    = 2'd0,
    FS_ACCEPTED = 2'd1,
    FS_BAD_SUM  = 2'd2,
    FS_HEADER   = 2'd3
  } frame_status_t;

  typedef enum logic [1:0] {
    MOTOR_IDLE    = 2'd0,
    MOTOR_OPENING = 2'd1,
    MOTOR_CLOSING = 2'd2
  } motor_t;

  typedef enum logic {
    DIR_OPENING = 1'b0,
    DIR_CLOSING = 1'b1
  } dir_t;

  localparam logic [7:0] HDR_FIRST   = 8'h55;
  localparam logic [7:0] HDR_SECOND  = 8'hAA;

  localparam int OFS_HDR_SECOND = 1;
  localparam int OFS_CMD     = 3;
  localparam int OFS_LEN_HI  = 4;
  localparam int OFS_LEN_LO  = 5;
  localparam int OFS_DP      = 6;
  localparam int OFS_TYPE    = 7;
  localparam int OFS_VALUE   = 10;
  localparam int OFS_POS     = 13;

  localparam logic [7:0] CMD_NET_RESET = 8'h04;
  localparam logic [7:0] CMD_STATUS    = 8'h07;

  localparam logic [7:0] DP_CTRL_HI    = 8'h65;
  localparam logic [7:0] DP_CTRL_LO    = 8'h01;
  localparam logic [7:0] DP_MOVE_HI    = 8'h66;
  localparam logic [7:0] DP_MOVE_LO    = 8'h07;
  localparam logic [7:0] DP_STOP_HI    = 8'h68;
  localparam logic [7:0] DP_STOP_LO    = 8'h03;
  localparam logic [7:0] DP_NET_RESET  = 8'h06;
  localparam logic [7:0] DP_SET_SPLIT  = 8'h10;
  localparam logic [7:0] TYPE_ENUM     = 8'h04;

  localparam logic [7:0] VAL_CLOSE = 8'd0;
  localparam logic [7:0] VAL_STOP  = 8'd1;
  localparam logic [7:0] VAL_OPEN  = 8'd2;

  localparam logic [7:0] POS_HIGH_BYTE = 8'd95;
  localparam logic [7:0] POS_LOW_BYTE  = 8'd5;
  localparam logic [6:0] POS_FULL      = 7'd100;
  localparam logic [6:0] POS_MID       = 7'd50;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic       gap_expired;
    logic [6:0] target_position;
  } item_t;

  // what a completed, checksum-correct frame carries to the motor logic
  typedef struct packed {
    logic       accepted;
    logic [7:0] cmd;
    logic       len_zero;
    logic [7:0] dp;
    logic [7:0] typ;
    logic [7:0] val;
    logic [7:0] pos;
    logic       has_value;
    logic       has_pos;
  } frame_evt_t;

endpackage

// File: rtl/core/cmfr_in_stage.sv
// Input register for requests, with stall towards the sender
module cmfr_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cmfr_pkg::item_t  in_item,
  input  logic             take,
  output logic             held_valid,
  output cmfr_pkg::item_t  held_item
);

  logic accept;

  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_item;
    end
  end

endmodule

// File: rtl/core/cmfr_frame_parser.sv
// Byte receiver: framing, length and checksum, captured frame fields
module cmfr_frame_parser #(
  parameter int BUF_BYTES = cmfr_pkg::BUF_BYTES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [7:0]                 rx_byte,
  input  logic                       gap_expired,
  output cmfr_pkg::frame_status_t    status,
  output logic                       dropped,
  output cmfr_pkg::frame_evt_t       evt
);

  localparam int CNT_W = $clog2(BUF_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUF_BYTES - 1);

  logic [CNT_W-1:0] count, count_next, cnt_gap, idx;
  logic [7:0] sum, sum_next;
  logic [7:0] len_hi, len_hi_next, len_lo, len_lo_next;
  logic [7:0] cmd, cmd_next, dp, dp_next, typ, typ_next;
  logic [7:0] val, val_next, posb, posb_next;
  logic [cmfr_pkg::LEN_W-1:0] end_idx;
  logic frame_end;

  always_comb begin
    count_next  = count;
    sum_next    = sum;
    len_hi_next = len_hi;
    len_lo_next = len_lo;
    cmd_next    = cmd;
    dp_next     = dp;
    typ_next    = typ;
    val_next    = val;
    posb_next   = posb;
    status      = cmfr_pkg::FS_TAKEN;
    dropped     = 1'b0;
    evt         = '0;
    frame_end   = 1'b0;
    cnt_gap     = gap_expired ? '0 : count;
    idx         = cnt_gap;
    end_idx     = '0;
    if (en) begin
      if (gap_expired && count != '0) begin
        dropped = 1'b1;
      end
      if (cnt_gap >= CNT_LAST) begin
        dropped = 1'b1;
        idx     = '0;
      end
      count_next = idx + CNT_W'(1);
      if (idx == '0) begin
        if (rx_byte != cmfr_pkg::HDR_FIRST) begin
          status     = cmfr_pkg::FS_HEADER;
          count_next = '0;
        end else begin
          sum_next = rx_byte;
        end
      end else if (idx == CNT_W'(cmfr_pkg::OFS_HDR_SECOND)) begin
        if (rx_byte != cmfr_pkg::HDR_SECOND) begin
          status     = cmfr_pkg::FS_HEADER;
          count_next = '0;
        end else begin
          sum_next = sum + rx_byte;
        end
      end else begin
        if (idx == CNT_W'(cmfr_pkg::OFS_CMD))    cmd_next    = rx_byte;
        if (idx == CNT_W'(cmfr_pkg::OFS_LEN_HI)) len_hi_next = rx_byte;
        if (idx == CNT_W'(cmfr_pkg::OFS_LEN_LO)) len_lo_next = rx_byte;
        if (idx == CNT_W'(cmfr_pkg::OFS_DP))     dp_next     = rx_byte;
        if (idx == CNT_W'(cmfr_pkg::OFS_TYPE))   typ_next    = rx_byte;
        if (idx == CNT_W'(cmfr_pkg::OFS_VALUE))  val_next    = rx_byte;
        if (idx == CNT_W'(cmfr_pkg::OFS_POS))    posb_next   = rx_byte;
        end_idx   = cmfr_pkg::LEN_W'({len_hi_next, len_lo_next})
                  + cmfr_pkg::LEN_W'(cmfr_pkg::OFS_DP);
        frame_end = (idx >= CNT_W'(cmfr_pkg::OFS_DP))
                 && (cmfr_pkg::LEN_W'(idx) == end_idx);
        if (frame_end) begin
          count_next = '0;
          if (sum == rx_byte) begin
            status       = cmfr_pkg::FS_ACCEPTED;
            evt.accepted = 1'b1;
          end else begin
            status = cmfr_pkg::FS_BAD_SUM;
          end
        end else begin
          sum_next = sum + rx_byte;
        end
      end
      evt.cmd       = cmd_next;
      evt.len_zero  = (len_hi_next == '0) && (len_lo_next == '0);
      evt.dp        = dp_next;
      evt.typ       = typ_next;
      evt.val       = val_next;
      evt.pos       = posb_next;
      evt.has_value = idx >= CNT_W'(cmfr_pkg::OFS_VALUE);
      evt.has_pos   = idx >= CNT_W'(cmfr_pkg::OFS_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sum    <= '0;
      len_hi <= '0;
      len_lo <= '0;
      cmd    <= '0;
      dp     <= '0;
      typ    <= '0;
      val    <= '0;
      posb   <= '0;
    end else begin
      count  <= count_next;
      sum    <= sum_next;
      len_hi <= len_hi_next;
      len_lo <= len_lo_next;
      cmd    <= cmd_next;
      dp     <= dp_next;
      typ    <= typ_next;
      val    <= val_next;
      posb   <= posb_next;
    end
  end

endmodule

// File: rtl/core/cmfr_motor_ctrl.sv
// Motor state, direction, position and flags from frames and host requests
module cmfr_motor_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  cmfr_pkg::frame_evt_t  evt,
  input  logic                  host_stop,
  input  logic                  host_move,
  input  logic [6:0]            target_position,
  output cmfr_pkg::motor_t      motor_next,
  output cmfr_pkg::dir_t        dir_next,
  output logic [6:0]            pos_next,
  output logic                  calib_next,
  output logic                  cmdset_next,
  output logic                  net_reset,
  output logic                  hand
);

  cmfr_pkg::motor_t motor;
  cmfr_pkg::dir_t   dir;
  logic [6:0] pos;
  logic calib, cmdset, hand_flag, hand_flag_next;
  logic [7:0] p_clamp;

  always_comb begin
    motor_next     = motor;
    dir_next       = dir;
    pos_next       = pos;
    calib_next     = calib;
    cmdset_next    = cmdset;
    hand_flag_next = hand_flag;
    net_reset      = 1'b0;
    hand           = 1'b0;
    p_clamp = (evt.pos >= cmfr_pkg::POS_HIGH_BYTE) ? 8'(cmfr_pkg::POS_FULL) : evt.pos;
    if (p_clamp <= cmfr_pkg::POS_LOW_BYTE) p_clamp = '0;
    if (evt.accepted) begin
      case (evt.cmd)
        cmfr_pkg::CMD_NET_RESET: begin
          if (evt.len_zero && evt.dp == cmfr_pkg::DP_NET_RESET) net_reset = 1'b1;
        end
        cmfr_pkg::CMD_STATUS: begin
          case (evt.dp)
            cmfr_pkg::DP_CTRL_HI, cmfr_pkg::DP_CTRL_LO: begin
              if (evt.typ == cmfr_pkg::TYPE_ENUM) begin
                cmdset_next = !(evt.dp > cmfr_pkg::DP_SET_SPLIT);
                case (evt.val)
                  cmfr_pkg::VAL_CLOSE: begin
                    motor_next = cmfr_pkg::MOTOR_CLOSING;
                    dir_next   = cmfr_pkg::DIR_CLOSING;
                  end
                  cmfr_pkg::VAL_STOP: begin
                    motor_next = cmfr_pkg::MOTOR_IDLE;
                  end
                  cmfr_pkg::VAL_OPEN: begin
                    motor_next = cmfr_pkg::MOTOR_OPENING;
                    dir_next   = cmfr_pkg::DIR_OPENING;
                  end
                  default: ;
                endcase
              end
            end
            cmfr_pkg::DP_MOVE_HI, cmfr_pkg::DP_MOVE_LO: begin
              if (cmdset && evt.has_value) begin
                dir_next = (evt.val == cmfr_pkg::VAL_STOP) ? cmfr_pkg::DIR_OPENING
                                                           : cmfr_pkg::DIR_CLOSING;
              end
              motor_next = (dir_next == cmfr_pkg::DIR_OPENING) ? cmfr_pkg::MOTOR_OPENING
                                                               : cmfr_pkg::MOTOR_CLOSING;
              if (evt.has_pos) begin
                pos_next = p_clamp[6:0];
                if (p_clamp[6:0] != cmfr_pkg::POS_MID) calib_next = 1'b1;
              end
              hand = hand_flag;
            end
            cmfr_pkg::DP_STOP_HI, cmfr_pkg::DP_STOP_LO: begin
              motor_next = cmfr_pkg::MOTOR_IDLE;
              if (evt.has_pos) begin
                pos_next = p_clamp[6:0];
                if (p_clamp[6:0] != cmfr_pkg::POS_MID) calib_next = 1'b1;
              end
              hand_flag_next = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (host_stop) hand_flag_next = 1'b0;
    if (host_move) begin
      hand_flag_next = 1'b0;
      if (target_position < pos) begin
        dir_next = cmfr_pkg::DIR_OPENING;
      end else if (target_position > pos) begin
        dir_next = cmfr_pkg::DIR_CLOSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor     <= cmfr_pkg::MOTOR_IDLE;
      dir       <= cmfr_pkg::DIR_CLOSING;
      pos       <= '0;
      calib     <= 1'b0;
      cmdset    <= 1'b0;
      hand_flag <= 1'b0;
    end else begin
      motor     <= motor_next;
      dir       <= dir_next;
      pos       <= pos_next;
      calib     <= calib_next;
      cmdset    <= cmdset_next;
      hand_flag <= hand_flag_next;
    end
  end

endmodule

// File: rtl/core/curtain_motor_frame_receiver_unit.sv
// Top level: curtain motor serial frame receiver
//
//  channel  handshake            payload
//  in       in_valid / in_stall  req_type rx_byte gap_expired target_position
//  out      out_valid/ out_stall frame_status dropped_partial motor_state direction
//                                position calibrated command_set network_reset
//                                hand_activity
//
// One request a cycle while the result register is not stalled; a result passes the input
// register, then the result register, before it is on the outputs.
// State is updated between the two registers, as the result register is loaded.
// rst is synchronous; it empties both registers and clears the receiver.
// A held result stalls processing; the input register still takes one request.
module curtain_motor_frame_receiver_unit #(
  parameter int BUF_BYTES = cmfr_pkg::BUF_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] rx_byte,
  input  logic       gap_expired,
  input  logic [6:0] target_position,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] frame_status,
  output logic       dropped_partial,
  output logic [1:0] motor_state,
  output logic       direction,
  output logic [6:0] position,
  output logic       calibrated,
  output logic       command_set,
  output logic       network_reset,
  output logic       hand_activity
);

  cmfr_pkg::item_t in_item, item;
  logic item_valid, room, proc, rx_en, host_stop, host_move;
  cmfr_pkg::frame_status_t status;
  logic dropped;
  cmfr_pkg::frame_evt_t evt;
  cmfr_pkg::motor_t motor_next;
  cmfr_pkg::dir_t dir_next;
  logic [6:0] pos_next;
  logic calib_next, cmdset_next, net_reset, hand;

  assign in_item = '{req_type: req_type, rx_byte: rx_byte,
                     gap_expired: gap_expired, target_position: target_position};

  assign room      = !out_valid || !out_stall;
  assign proc      = item_valid && room;
  assign rx_en     = proc && (item.req_type == cmfr_pkg::REQ_RX);
  assign host_stop = proc && (item.req_type == cmfr_pkg::REQ_STOP);
  assign host_move = proc && (item.req_type == cmfr_pkg::REQ_MOVE);

  cmfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (room),
    .held_valid (item_valid),
    .held_item  (item)
  );

  cmfr_frame_parser #(
    .BUF_BYTES (BUF_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .en          (rx_en),
    .rx_byte     (item.rx_byte),
    .gap_expired (item.gap_expired),
    .status      (status),
    .dropped     (dropped),
    .evt         (evt)
  );

  cmfr_motor_ctrl u_motor (
    .clk             (clk),
    .rst             (rst),
    .evt             (evt),
    .host_stop       (host_stop),
    .host_move       (host_move),
    .target_position (item.target_position),
    .motor_next      (motor_next),
    .dir_next        (dir_next),
    .pos_next        (pos_next),
    .calib_next      (calib_next),
    .cmdset_next     (cmdset_next),
    .net_reset       (net_reset),
    .hand            (hand)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      frame_status    <= status;
      dropped_partial <= dropped;
      motor_state     <= motor_next;
      direction       <= dir_next;
      position        <= pos_next;
      calibrated      <= calib_next;
      command_set     <= cmdset_next;
      network_reset   <= net_reset;
      hand_activity   <= hand;
    end
  end

endmodule

// File: rtl/core/cmfr_port_checker.sv
// Port checker for the curtain motor frame receiver, bound to the top level
`include "curtain_motor_frame_receiver_unit_macros.svh"

module cmfr_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] frame_status,
  input logic [6:0] position,
  input logic       network_reset,
  input logic       hand_activity
);

  `CMFR_ASSERT(a_out_hold, clk, rst,
               out_valid && out_stall |=> out_valid && $stable(frame_status)
                 && $stable(position),
               "stalled result changed")
  `CMFR_ASSERT(a_pos_range, clk, rst, out_valid |-> position <= cmfr_pkg::POS_FULL,
               "position above full scale")
  `CMFR_ASSERT(a_pulse_excl, clk, rst, out_valid |-> !(network_reset && hand_activity),
               "both pulses in one result")
  `CMFR_ASSERT(a_pulse_frame, clk, rst,
               out_valid && frame_status != cmfr_pkg::FS_ACCEPTED
                 |-> !network_reset && !hand_activity,
               "pulse without accepted frame")
  `CMFR_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind curtain_motor_frame_receiver_unit cmfr_port_checker u_port_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .frame_status  (frame_status),
  .position      (position),
  .network_reset (network_reset),
  .hand_activity (hand_activity)
);

// File: tb/curtain_motor_report_checker.sv
`timescale 1ns / 100ps
// Checker for the curtain motor frame receiver: predicts each report and compares it
module curtain_motor_report_checker #(
  parameter int BUF_BYTES = cmfr_pkg::BUF_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] rx_byte,
  input  logic       gap_expired,
  input  logic [6:0] target_position,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] frame_status,
  input  logic       dropped_partial,
  input  logic [1:0] motor_state,
  input  logic       direction,
  input  logic [6:0] position,
  input  logic       calibrated,
  input  logic       command_set,
  input  logic       network_reset,
  input  logic       hand_activity,
  output int         mismatch_count,
  output int         reports_pending
);

  typedef struct packed {
    cmfr_pkg::frame_status_t status;
    logic                    dropped;
    cmfr_pkg::motor_t        motor;
    cmfr_pkg::dir_t          dir;
    logic [6:0]              pos;
    logic                    calib;
    logic                    cmdset;
    logic                    net_reset;
    logic                    hand;
  } motor_report_t;

  motor_report_t reports_due[$];
  int errors = 0;

  // receiver and motor state as the block should hold it
  int unsigned      rx_count;
  logic [7:0]       frame_sum, len_hi, len_lo, cmd_b, dp_b, type_b, value_b, pos_b;
  cmfr_pkg::motor_t motor_r;
  cmfr_pkg::dir_t   dir_r;
  logic [6:0]       pos_r;
  logic             calib_r, cmdset_r, hand_flag;

  function automatic void take_reported_position();
    if (pos_b >= cmfr_pkg::POS_HIGH_BYTE) pos_r = cmfr_pkg::POS_FULL;
    else if (pos_b <= cmfr_pkg::POS_LOW_BYTE) pos_r = '0;
    else pos_r = pos_b[6:0];
    if (pos_r != cmfr_pkg::POS_MID) calib_r = 1'b1;
  endfunction

  function automatic motor_report_t advance_receiver(logic [1:0] rq, logic [7:0] b, logic gap,
                                                    logic [6:0] target);
    motor_report_t r;
    int unsigned ofs;
    int unsigned frame_len;
    r = '0;
    r.status = cmfr_pkg::FS_TAKEN;
    if (rq == cmfr_pkg::REQ_RX) begin
      if (gap) begin
        if (rx_count > 0) r.dropped = 1'b1;
        rx_count = 0;
      end
      if (rx_count >= BUF_BYTES - 1) begin
        r.dropped = 1'b1;
        rx_count = 0;
      end
      ofs = rx_count;
      rx_count = ofs + 1;
      if (ofs == 0) begin
        if (b != cmfr_pkg::HDR_FIRST) begin
          r.status = cmfr_pkg::FS_HEADER;
          rx_count = 0;
        end else frame_sum = b;
      end else if (ofs == cmfr_pkg::OFS_HDR_SECOND) begin
        if (b != cmfr_pkg::HDR_SECOND) begin
          r.status = cmfr_pkg::FS_HEADER;
          rx_count = 0;
        end else frame_sum = frame_sum + b;
      end else begin
        case (ofs)
          cmfr_pkg::OFS_CMD:    cmd_b = b;
          cmfr_pkg::OFS_LEN_HI: len_hi = b;
          cmfr_pkg::OFS_LEN_LO: len_lo = b;
          cmfr_pkg::OFS_DP:     dp_b = b;
          cmfr_pkg::OFS_TYPE:   type_b = b;
          cmfr_pkg::OFS_VALUE:  value_b = b;
          cmfr_pkg::OFS_POS:    pos_b = b;
          default: ;
        endcase
        frame_len = 32'({len_hi, len_lo});
        if (ofs >= cmfr_pkg::OFS_DP && ofs == cmfr_pkg::OFS_DP + frame_len) begin
          rx_count = 0;
          if (frame_sum != b) r.status = cmfr_pkg::FS_BAD_SUM;
          else begin
            r.status = cmfr_pkg::FS_ACCEPTED;
            if (cmd_b == cmfr_pkg::CMD_NET_RESET) begin
              if (frame_len == 0 && dp_b == cmfr_pkg::DP_NET_RESET) r.net_reset = 1'b1;
            end else if (cmd_b == cmfr_pkg::CMD_STATUS) begin
              case (dp_b)
                cmfr_pkg::DP_CTRL_HI, cmfr_pkg::DP_CTRL_LO: begin
                  if (type_b == cmfr_pkg::TYPE_ENUM) begin
                    cmdset_r = (dp_b > cmfr_pkg::DP_SET_SPLIT) ? 1'b0 : 1'b1;
                    case (value_b)
                      cmfr_pkg::VAL_CLOSE: begin
                        motor_r = cmfr_pkg::MOTOR_CLOSING;
                        dir_r = cmfr_pkg::DIR_CLOSING;
                      end
                      cmfr_pkg::VAL_STOP: motor_r = cmfr_pkg::MOTOR_IDLE;
                      cmfr_pkg::VAL_OPEN: begin
                        motor_r = cmfr_pkg::MOTOR_OPENING;
                        dir_r = cmfr_pkg::DIR_OPENING;
                      end
                      default: ;
                    endcase
                  end
                end
                cmfr_pkg::DP_MOVE_HI, cmfr_pkg::DP_MOVE_LO: begin
                  // low set: value 1 means opening, anything else closing
                  if (cmdset_r && ofs >= cmfr_pkg::OFS_VALUE)
                    dir_r = (value_b == cmfr_pkg::VAL_STOP) ? cmfr_pkg::DIR_OPENING
                                                            : cmfr_pkg::DIR_CLOSING;
                  motor_r = (dir_r == cmfr_pkg::DIR_OPENING) ? cmfr_pkg::MOTOR_OPENING
                                                             : cmfr_pkg::MOTOR_CLOSING;
                  if (ofs >= cmfr_pkg::OFS_POS) take_reported_position();
                  if (hand_flag) r.hand = 1'b1;
                end
                cmfr_pkg::DP_STOP_HI, cmfr_pkg::DP_STOP_LO: begin
                  motor_r = cmfr_pkg::MOTOR_IDLE;
                  if (ofs >= cmfr_pkg::OFS_POS) take_reported_position();
                  hand_flag = 1'b1;
                end
                default: ;
              endcase
            end
          end
        end else frame_sum = frame_sum + b;
      end
    end else if (rq == cmfr_pkg::REQ_STOP) begin
      hand_flag = 1'b0;
    end else if (rq == cmfr_pkg::REQ_MOVE) begin
      hand_flag = 1'b0;
      if (target < pos_r) dir_r = cmfr_pkg::DIR_OPENING;
      else if (target > pos_r) dir_r = cmfr_pkg::DIR_CLOSING;
    end
    r.motor = motor_r;
    r.dir = dir_r;
    r.pos = pos_r;
    r.calib = calib_r;
    r.cmdset = cmdset_r;
    return r;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    motor_report_t due;
    if (rst) begin
      rx_count = 0;
      frame_sum = '0;
      len_hi = '0;
      len_lo = '0;
      cmd_b = '0;
      dp_b = '0;
      type_b = '0;
      value_b = '0;
      pos_b = '0;
      motor_r = cmfr_pkg::MOTOR_IDLE;
      dir_r = cmfr_pkg::DIR_CLOSING;
      pos_r = '0;
      calib_r = 1'b0;
      cmdset_r = 1'b0;
      hand_flag = 1'b0;
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t unexpected report: expected none, actual status %0d", $time,
                   frame_status);
        end else begin
          due = reports_due.pop_front();
          check_field("frame_status", 8'(due.status), 8'(frame_status));
          check_field("dropped_partial", 8'(due.dropped), 8'(dropped_partial));
          check_field("motor_state", 8'(due.motor), 8'(motor_state));
          check_field("direction", 8'(due.dir), 8'(direction));
          check_field("position", 8'(due.pos), 8'(position));
          check_field("calibrated", 8'(due.calib), 8'(calibrated));
          check_field("command_set", 8'(due.cmdset), 8'(command_set));
          check_field("network_reset", 8'(due.net_reset), 8'(network_reset));
          check_field("hand_activity", 8'(due.hand), 8'(hand_activity));
        end
      end
      if (in_valid && !in_stall)
        reports_due.push_back(advance_receiver(req_type, rx_byte, gap_expired,
                                               target_position));
    end
    reports_pending <= reports_due.size();
    mismatch_count <= errors;
  end

endmodule

// File: tb/curtain_motor_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives serial bytes and host notices into the frame receiver
module curtain_motor_frame_receiver_unit_tb;

  localparam int BUF_BYTES = cmfr_pkg::BUF_BYTES_DEFAULT;
  localparam int REQUEST_TOTAL = 1450;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic       clk, rst;
  logic       in_valid, in_stall;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic       gap_expired;
  logic [6:0] target_position;
  logic       out_valid, out_stall;
  logic [1:0] frame_status;
  logic       dropped_partial;
  logic [1:0] motor_state;
  logic       direction;
  logic [6:0] position;
  logic       calibrated, command_set, network_reset, hand_activity;
  int         mismatch_count, reports_pending;

  int requests_sent = 0;
  int sender_idle_pct = 0;
  int out_stall_pct = 0;
  int holds_asked = 0;

  curtain_motor_frame_receiver_unit #(.BUF_BYTES(BUF_BYTES)) i_dut (.*);
  curtain_motor_report_checker #(.BUF_BYTES(BUF_BYTES)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls, or a long hold-off when asked
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("[curtain_motor_frame_receiver_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic offer_request(input logic [1:0] kind, input logic [7:0] data, input logic gap,
                               input logic [6:0] target);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    rx_byte <= data;
    gap_expired <= gap;
    target_position <= target;
    do @(posedge clk); while (in_stall);
    if (kind != REQ_UNUSED) requests_sent++;
  endtask

  task automatic offer_byte(input logic [7:0] data, input logic gap);
    offer_request(cmfr_pkg::REQ_RX, data, gap, 7'($urandom_range(127)));
  endtask

  // frame: header, version, command, length, payload, additive sum;
  // cut_at >= 0 sends only that many bytes
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] cmd, input logic [15:0] len,
                            input logic [7:0] dp, input logic [7:0] typ, input logic [7:0] val,
                            input logic [7:0] pos, input bit bad_sum, input bit lead_gap,
                            input int cut_at);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    int n;
    frame_bytes = {cmfr_pkg::HDR_FIRST, cmfr_pkg::HDR_SECOND, ver, cmd, len[15:8], len[7:0]};
    for (int i = 0; i < len; i++) begin
      if (i + cmfr_pkg::OFS_DP == cmfr_pkg::OFS_DP) frame_bytes.push_back(dp);
      else if (i + cmfr_pkg::OFS_DP == cmfr_pkg::OFS_TYPE) frame_bytes.push_back(typ);
      else if (i + cmfr_pkg::OFS_DP == cmfr_pkg::OFS_VALUE) frame_bytes.push_back(val);
      else if (i + cmfr_pkg::OFS_DP == cmfr_pkg::OFS_POS) frame_bytes.push_back(pos);
      else frame_bytes.push_back(8'($urandom));
    end
    sum = '0;
    foreach (frame_bytes[k]) sum = sum + frame_bytes[k];
    if (bad_sum) sum = sum + 8'd1 + 8'($urandom_range(254));
    frame_bytes.push_back(sum);
    n = (cut_at >= 0 && cut_at < frame_bytes.size()) ? cut_at : frame_bytes.size();
    for (int k = 0; k < n; k++) offer_byte(frame_bytes[k], (k == 0) ? lead_gap : 1'b0);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
  endtask

  initial begin : stimulus
    logic [7:0]  ver, cmd, dp, typ, val, pos;
    logic [15:0] len;
    int          pick, phase;
    bit          first_hold_done;
    phase = 0;
    first_hold_done = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= cmfr_pkg::REQ_RX;
    rx_byte <= '0;
    gap_expired <= 1'b0;
    target_position <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 37;
    out_stall_pct <= 52;

    // header rejects, gap with nothing pending, gap over a partial frame
    offer_byte(8'h00, 1'b0);
    offer_byte(cmfr_pkg::HDR_FIRST, 1'b1);
    offer_byte(8'hFF, 1'b0);
    offer_byte(cmfr_pkg::HDR_FIRST, 1'b0);
    offer_byte(cmfr_pkg::HDR_SECOND, 1'b0);
    // empty net reset frame: the checksum byte doubles as the datapoint
    send_frame(cmfr_pkg::DP_NET_RESET - cmfr_pkg::HDR_FIRST - cmfr_pkg::HDR_SECOND
                 - cmfr_pkg::CMD_NET_RESET,
               cmfr_pkg::CMD_NET_RESET, '0, '0, '0, '0, '0, 1'b0, 1'b1, -1);
    send_frame(8'hFF, 8'hFF, '0, '0, '0, '0, '0, 1'b1, 1'b0, -1);
    offer_request(cmfr_pkg::REQ_MOVE, 8'hFF, 1'b1, 7'd127);
    offer_request(cmfr_pkg::REQ_STOP, 8'h00, 1'b0, 7'd0);
    offer_request(REQ_UNUSED, 8'($urandom), 1'($urandom_range(1)), 7'($urandom_range(127)));

    while (requests_sent < REQUEST_TOTAL) begin
      if (phase == 0 && requests_sent >= REQUEST_TOTAL / 3) begin
        drain_reports();
        sender_idle_pct = 52;
        out_stall_pct <= 37;
        phase = 1;
      end else if (phase == 1 && requests_sent >= 2 * REQUEST_TOTAL / 3) begin
        drain_reports();
        sender_idle_pct = 0;
        out_stall_pct <= 0;
        holds_asked <= holds_asked + 1;
        phase = 2;
      end
      if (!first_hold_done && requests_sent >= 200) begin
        holds_asked <= holds_asked + 1;
        first_hold_done = 1;
      end

      pick = $urandom_range(99);
      if (pick < 70 || pick >= 92) begin
        cmd = ($urandom_range(99) < 75) ? cmfr_pkg::CMD_STATUS :
              ($urandom_range(1) ? cmfr_pkg::CMD_NET_RESET : 8'($urandom));
        case ($urandom_range(7))
          0: dp = cmfr_pkg::DP_CTRL_HI;
          1: dp = cmfr_pkg::DP_CTRL_LO;
          2: dp = cmfr_pkg::DP_MOVE_HI;
          3: dp = cmfr_pkg::DP_MOVE_LO;
          4: dp = cmfr_pkg::DP_STOP_HI;
          5: dp = cmfr_pkg::DP_STOP_LO;
          6: dp = cmfr_pkg::DP_NET_RESET;
          default: dp = 8'($urandom);
        endcase
        typ = ($urandom_range(99) < 80) ? cmfr_pkg::TYPE_ENUM : 8'($urandom);
        val = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom);
        case ($urandom_range(7))
          0: pos = 8'($urandom_range(cmfr_pkg::POS_LOW_BYTE));
          1: pos = 8'($urandom_range(cmfr_pkg::POS_HIGH_BYTE, 255));
          2: pos = 8'(cmfr_pkg::POS_MID);
          default: pos = 8'($urandom);
        endcase
        case ($urandom_range(3))
          0: len = 16'($urandom_range(3));
          1: len = 16'($urandom_range(4, 6));
          default: len = 16'($urandom_range(7, 12));
        endcase
        if (cmd == cmfr_pkg::CMD_NET_RESET && $urandom_range(3) != 0) len = '0;
        ver = (len == 0) ? cmfr_pkg::DP_NET_RESET - cmfr_pkg::HDR_FIRST - cmfr_pkg::HDR_SECOND
                             - cmd
                         : 8'($urandom);
        send_frame(ver, cmd, len, dp, typ, val, pos, $urandom_range(99) < 8,
                   $urandom_range(99) < 10,
                   ($urandom_range(99) < 5) ? int'($urandom_range(1, 12)) : -1);
      end else if (pick < 80) begin
        offer_request($urandom_range(1) ? cmfr_pkg::REQ_MOVE : cmfr_pkg::REQ_STOP,
                      8'($urandom), 1'($urandom_range(1)), 7'($urandom_range(127)));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) offer_byte(8'($urandom), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        offer_request(REQ_UNUSED, 8'($urandom), 1'($urandom_range(1)),
                      7'($urandom_range(127)));
      end else begin
        // runs into the buffer limit, or lands close to it on either side
        len = $urandom_range(1) ? 16'($urandom_range(119, 122)) : 16'($urandom_range(123, 200));
        send_frame(8'($urandom), cmfr_pkg::CMD_STATUS, len, cmfr_pkg::DP_MOVE_HI,
                   cmfr_pkg::TYPE_ENUM, 8'($urandom), 8'($urandom), 1'b0,
                   1'($urandom_range(1)), -1);
      end
    end

    drain_reports();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) $display("[curtain_motor_frame_receiver_unit] OK");
    else $display("[curtain_motor_frame_receiver_unit] ERROR");
    $finish;
  end

endmodule

// File: curtain_motor_frame_receiver_unit.f
+incdir+rtl/core
rtl/core/cmfr_pkg.sv
rtl/core/cmfr_in_stage.sv
rtl/core/cmfr_frame_parser.sv
rtl/core/cmfr_motor_ctrl.sv
rtl/core/curtain_motor_frame_receiver_unit.sv
rtl/core/cmfr_port_checker.sv
tb/curtain_motor_report_checker.sv
tb/curtain_motor_frame_receiver_unit_tb.sv
